### hw/rtl/som_bmu_pkg.sv
// Shared types and constants for the self-organizing map best-matching-unit search.
// Holds the request and result structs, code enums and the token passed along the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package som_bmu_pkg;

    // Field widths fixed by the interface.
    localparam int VAL_W      = 16;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int ELEM_W     = 4;
    localparam int DIST_W     = 36;
    localparam int SQ_W       = 32;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = 36'hF_FFFF_FFFF;

    // Register reset values.
    localparam logic [CFG_W-1:0] ROWS_USED_RST = 5'd16;
    localparam logic [CFG_W-1:0] COLS_USED_RST = 5'd16;
    localparam logic [CFG_W-1:0] VEC_LEN_RST   = 5'd16;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METRIC_MODE = 8'd0,
        CFG_ROWS_USED   = 8'd1,
        CFG_COLS_USED   = 8'd2,
        CFG_VEC_LEN     = 8'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                      operation;
        logic [ROW_W-1:0]         unit_row;
        logic [COL_W-1:0]         unit_col;
        logic [ELEM_W-1:0]        element_index;
        logic signed [VAL_W-1:0]  value;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  best_row;
        logic [COL_W-1:0]  best_col;
        logic [DIST_W-1:0] best_distance;
    } result_t;

    // Control that travels with each weight element through the cell row.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } cell_tok_t;

endpackage

`default_nettype wire

### hw/rtl/som_bmu_cell.sv
// One cell of the distance row: squares the difference of a passing weight element and
// the broadcast query element, accumulates one shift's distance and folds it into a running minimum.
// Depends on som_bmu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module som_bmu_cell
    import som_bmu_pkg::*;
#(
    parameter int ACC_W = 37
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    active,
    input  wire cell_tok_t               tok_in,
    input  wire logic signed [VAL_W-1:0] w_in,
    input  wire logic signed [VAL_W-1:0] q_in,
    output cell_tok_t                    tok_out,
    output logic signed [VAL_W-1:0]      w_out,
    input  wire logic [ACC_W-1:0]        min_in,
    input  wire logic                    min_vld_in,
    output logic [ACC_W-1:0]             min_out,
    output logic                         min_vld_out
);

    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] prod;
    cell_tok_t                 tok_reg;
    logic signed [VAL_W-1:0]   w_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic                      done_reg;
    logic [ACC_W-1:0]          min_reg;
    logic                      min_vld_reg;

    // The difference fits in 17 bits, so its square fits in 32.
    assign diff = {w_in[VAL_W-1], w_in} - {q_in[VAL_W-1], q_in};
    assign prod = diff * diff;

    // Square stage; the weight moves on to the neighbor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_in;
        sq_reg <= prod[SQ_W-1:0];
    end

    // Accumulate one unit's distance for this cell's shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (tok_reg.vld)
            begin
                acc_reg <= (tok_reg.first ? '0 : acc_reg) + ACC_W'(sq_reg);
            end
            done_reg <= tok_reg.vld && tok_reg.last;
        end
    end

    // Running minimum over shifts; an inactive cell only delays it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= '0;
            min_vld_reg <= 1'b0;
        end
        else if (!active)
        begin
            min_reg     <= min_in;
            min_vld_reg <= min_vld_in;
        end
        else if (done_reg)
        begin
            min_reg     <= (min_vld_in && (min_in < acc_reg)) ? min_in : acc_reg;
            min_vld_reg <= 1'b1;
        end
        else
        begin
            min_vld_reg <= 1'b0;
        end
    end

    assign tok_out     = tok_reg;
    assign w_out       = w_reg;
    assign min_out     = min_reg;
    assign min_vld_out = min_vld_reg;

endmodule

`default_nettype wire

### hw/rtl/som_best_match_unit_search_core.sv
// Top level of the best-matching-unit search: weight memory, query buffer, sequencer,
// the row of distance cells and the winner compare. Depends on som_bmu_pkg and som_bmu_cell.
`timescale 1ns / 1ps
`default_nettype none

// Weight and query requests are taken while the core is idle. A query request with last set
// starts a search that reads one weight element per cycle from the weight memory. A search
// takes as long in plain mode as in cyclic mode: the row of MAX_DIM cells computes all cyclic
// shifts of one element in parallel while the weights flow from cell to cell. The next request
// can be taken as soon as the result becomes valid. No request is taken during a search. A
// finished result waits in an output register while new requests are taken. If an earlier
// result is still waiting when a search ends, the core holds until that result is taken. There
// is no clearing pass after reset; weights and query elements read before they are written
// hold unknown values.
module som_best_match_unit_search_core
    import som_bmu_pkg::*;
#(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16,
    parameter int MAX_DIM   = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH      = GRID_ROWS * GRID_COLS * MAX_DIM;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW         = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW         = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int DW         = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ROW_STRIDE = GRID_COLS * MAX_DIM;
    localparam int ACC_W      = SQ_W + $clog2(MAX_DIM + 1);
    localparam int SAT_W      = (ACC_W > DIST_W) ? ACC_W : DIST_W;

    state_t state_reg, state_next;

    logic             metric_mode_reg;
    logic [CFG_W-1:0] rows_used_reg;
    logic [CFG_W-1:0] cols_used_reg;
    logic [CFG_W-1:0] vec_len_reg;

    logic [RW-1:0] nrm1;
    logic [CW-1:0] ncm1;
    logic [DW-1:0] nm1;

    logic signed [VAL_W-1:0] wmem [DEPTH];
    logic signed [VAL_W-1:0] qbuf [MAX_DIM];

    logic                    item_acc;
    logic                    mem_we;
    logic                    q_we;
    logic                    start;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic signed [VAL_W-1:0] mem_rd_reg;
    logic signed [VAL_W-1:0] q_reg;

    logic [RW-1:0] iss_r_reg;
    logic [CW-1:0] iss_c_reg;
    logic [DW-1:0] iss_i_reg;
    logic [DW-1:0] k_reg;
    logic [AW-1:0] row_base_reg;
    logic [AW-1:0] unit_base_reg;
    logic          issue_end;
    cell_tok_t     tok_a;
    cell_tok_t     tok_b_reg;

    cell_tok_t               tok_w  [MAX_DIM+1];
    logic signed [VAL_W-1:0] w_w    [MAX_DIM+1];
    logic [ACC_W-1:0]        min_w  [MAX_DIM+1];
    logic                    minv_w [MAX_DIM+1];
    logic [MAX_DIM-1:0]      act;

    logic             res_vld;
    logic [ACC_W-1:0] res_d;
    logic             res_final;
    logic [RW-1:0]    res_r_reg;
    logic [CW-1:0]    res_c_reg;
    logic [ACC_W-1:0] best_d_reg;
    logic [RW-1:0]    best_r_reg;
    logic [CW-1:0]    best_c_reg;
    logic [SAT_W-1:0] best_ext;
    logic             result_valid_reg;
    result_t          result_reg;
    logic             out_load;

    // Clamp the register values to the grid and vector bounds (stored minus one).
    always_comb
    begin
        if (rows_used_reg == '0)
            nrm1 = '0;
        else if (32'(rows_used_reg) > GRID_ROWS)
            nrm1 = RW'(GRID_ROWS - 1);
        else
            nrm1 = RW'(rows_used_reg - 5'd1);

        if (cols_used_reg == '0)
            ncm1 = '0;
        else if (32'(cols_used_reg) > GRID_COLS)
            ncm1 = CW'(GRID_COLS - 1);
        else
            ncm1 = CW'(cols_used_reg - 5'd1);

        if (vec_len_reg == '0)
            nm1 = '0;
        else if (32'(vec_len_reg) > MAX_DIM)
            nm1 = DW'(MAX_DIM - 1);
        else
            nm1 = DW'(vec_len_reg - 5'd1);
    end

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_mode_reg <= 1'b0;
            rows_used_reg   <= ROWS_USED_RST;
            cols_used_reg   <= COLS_USED_RST;
            vec_len_reg     <= VEC_LEN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_METRIC_MODE: metric_mode_reg <= cfg_data[0];
                CFG_ROWS_USED:   rows_used_reg   <= cfg_data[CFG_W-1:0];
                CFG_COLS_USED:   cols_used_reg   <= cfg_data[CFG_W-1:0];
                CFG_VEC_LEN:     vec_len_reg     <= cfg_data[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // Request decode.
    assign item_ready = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign mem_we     = item_acc && (item.operation == OP_WRITE)
                        && (32'(item.unit_row) < GRID_ROWS)
                        && (32'(item.unit_col) < GRID_COLS)
                        && (32'(item.element_index) < MAX_DIM);
    assign q_we       = item_acc && (item.operation == OP_QUERY)
                        && (32'(item.element_index) < MAX_DIM);
    assign start      = item_acc && (item.operation == OP_QUERY) && item.last;
    assign waddr      = AW'(ROW_STRIDE) * AW'(item.unit_row)
                        + AW'(MAX_DIM) * AW'(item.unit_col)
                        + AW'(item.element_index);
    assign raddr      = unit_base_reg + AW'(iss_i_reg);

    // Weight memory and query buffer, both with registered reads.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wmem[waddr] <= item.value;
        end
        mem_rd_reg <= wmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qbuf[DW'(item.element_index)] <= item.value;
        end
        q_reg <= qbuf[k_reg];
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign issue_end = (iss_i_reg == nm1) && (iss_c_reg == ncm1) && (iss_r_reg == nrm1);
    assign res_final = (res_r_reg == nrm1) && (res_c_reg == ncm1);
    assign out_load  = (state_reg == S_DONE) && (!result_valid_reg || result_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_ISSUE;
            S_ISSUE: if (issue_end) state_next = S_DRAIN;
            S_DRAIN: if (res_vld && res_final) state_next = S_DONE;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Issue counters walk units row-major and elements within a unit.
    // The query index runs modulo the vector length from the first issue on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_r_reg     <= '0;
            iss_c_reg     <= '0;
            iss_i_reg     <= '0;
            k_reg         <= '0;
            row_base_reg  <= '0;
            unit_base_reg <= '0;
        end
        else if (start)
        begin
            iss_r_reg     <= '0;
            iss_c_reg     <= '0;
            iss_i_reg     <= '0;
            k_reg         <= '0;
            row_base_reg  <= '0;
            unit_base_reg <= '0;
        end
        else
        begin
            if (state_reg == S_ISSUE || state_reg == S_DRAIN)
            begin
                k_reg <= (k_reg == nm1) ? '0 : k_reg + 1'b1;
            end
            if (state_reg == S_ISSUE)
            begin
                if (iss_i_reg != nm1)
                begin
                    iss_i_reg <= iss_i_reg + 1'b1;
                end
                else
                begin
                    iss_i_reg <= '0;
                    if (iss_c_reg != ncm1)
                    begin
                        iss_c_reg     <= iss_c_reg + 1'b1;
                        unit_base_reg <= unit_base_reg + AW'(MAX_DIM);
                    end
                    else
                    begin
                        iss_c_reg     <= '0;
                        iss_r_reg     <= iss_r_reg + 1'b1;
                        row_base_reg  <= row_base_reg + AW'(ROW_STRIDE);
                        unit_base_reg <= row_base_reg + AW'(ROW_STRIDE);
                    end
                end
            end
        end
    end

    // Token for the element being read; it meets the read data in the next cycle.
    assign tok_a.vld   = (state_reg == S_ISSUE);
    assign tok_a.first = (iss_i_reg == '0);
    assign tok_a.last  = (iss_i_reg == nm1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_b_reg <= '0;
        else
            tok_b_reg <= tok_a;
    end

    // Row of cells; cell p computes the distance for the query shifted by p.
    assign tok_w[0]  = tok_b_reg;
    assign w_w[0]    = mem_rd_reg;
    assign min_w[0]  = '0;
    assign minv_w[0] = 1'b0;

    for (genvar p = 0; p < MAX_DIM; p++)
    begin : g_cell
        assign act[p] = metric_mode_reg ? (32'(nm1) >= p) : (p == 0);

        som_bmu_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .active      (act[p]),
            .tok_in      (tok_w[p]),
            .w_in        (w_w[p]),
            .q_in        (q_reg),
            .tok_out     (tok_w[p+1]),
            .w_out       (w_w[p+1]),
            .min_in      (min_w[p]),
            .min_vld_in  (minv_w[p]),
            .min_out     (min_w[p+1]),
            .min_vld_out (minv_w[p+1])
        );
    end

    assign res_vld = minv_w[MAX_DIM];
    assign res_d   = min_w[MAX_DIM];

    // Winner compare: the first strict minimum in row-major order is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_r_reg  <= '0;
            res_c_reg  <= '0;
            best_d_reg <= '0;
            best_r_reg <= '0;
            best_c_reg <= '0;
        end
        else if (start)
        begin
            res_r_reg <= '0;
            res_c_reg <= '0;
        end
        else if (res_vld)
        begin
            if (((res_r_reg == '0) && (res_c_reg == '0)) || (res_d < best_d_reg))
            begin
                best_d_reg <= res_d;
                best_r_reg <= res_r_reg;
                best_c_reg <= res_c_reg;
            end
            if (res_c_reg != ncm1)
            begin
                res_c_reg <= res_c_reg + 1'b1;
            end
            else
            begin
                res_c_reg <= '0;
                res_r_reg <= res_r_reg + 1'b1;
            end
        end
    end

    // Output register with saturation of the distance.
    assign best_ext = SAT_W'(best_d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else if (out_load)
        begin
            result_valid_reg         <= 1'b1;
            result_reg.best_row      <= ROW_W'(best_r_reg);
            result_reg.best_col      <= COL_W'(best_c_reg);
            result_reg.best_distance <= (best_ext > SAT_W'(DIST_MAX)) ? DIST_MAX
                                                                      : DIST_W'(best_ext);
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A unit distance leaves the cell row only while a search is running.
    a_res_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld |-> (state_reg == S_ISSUE || state_reg == S_DRAIN))
        else $error("unit distance outside a search");

    // The end of the row never carries an element outside a search.
    a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok_w[MAX_DIM].vld |-> (state_reg == S_ISSUE || state_reg == S_DRAIN))
        else $error("weight element outside a search");

    // A final query request always starts issuing in the next cycle.
    a_start_issue: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == S_ISSUE && iss_i_reg == '0 && k_reg == '0))
        else $error("search did not start");

    // A new result appears only when a search completes.
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without a finished search");

endmodule

`default_nettype wire

### tb/som_best_match_unit_search_core_test.sv
// Self-checking testbench for the best-matching-unit search core.
// It drives weight, query and register requests, predicts each result from its own map
// model or from a fixed value in the plan, and needs only som_bmu_pkg, som_bmu_cell and the core RTL.
`timescale 1ns / 1ps

module som_best_match_unit_search_core_test;
    import som_bmu_pkg::*;

    localparam int NDIM = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_GOAL = 1050;
    localparam int QUIET_AFTER = 880;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_VEC_LEN + 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Map model: weight grid, query vector, registers and which entries hold data.
    logic signed [VAL_W-1:0] weight_mem [NDIM][NDIM][NDIM];
    logic signed [VAL_W-1:0] query_mem [NDIM];
    bit weight_set [NDIM][NDIM][NDIM];
    bit query_set [NDIM];
    logic cyclic_mode = 1'b0;
    logic [CFG_W-1:0] rows_reg = ROWS_USED_RST;
    logic [CFG_W-1:0] cols_reg = COLS_USED_RST;
    logic [CFG_W-1:0] len_reg = VEC_LEN_RST;

    result_t best_match_q[$];
    int mismatches = 0;
    int items_sent = 0;
    int matches_seen = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    typedef struct {
        bit is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        item_t req;
        bit typed;
        result_t res;
    } step_t;

    som_best_match_unit_search_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d results pending", best_match_q.size());
            $display("som_best_match_unit_search_core test failed");
            $finish;
        end
    end

    function automatic int clamp_count(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > NDIM)
            return NDIM;
        return int'(v);
    endfunction

    // Row-major scan; in cyclic mode each unit takes its best shift of the query.
    function automatic result_t find_best_match();
        int nr, nc, n, shifts, diff;
        longint acc, unit_d, best_d;
        result_t r;
        bit found;
        nr = clamp_count(rows_reg);
        nc = clamp_count(cols_reg);
        n = clamp_count(len_reg);
        shifts = cyclic_mode ? n : 1;
        found = 1'b0;
        best_d = 0;
        r = '0;
        for (int row = 0; row < nr; row++)
            for (int col = 0; col < nc; col++)
            begin
                unit_d = 0;
                for (int p = 0; p < shifts; p++)
                begin
                    acc = 0;
                    for (int i = 0; i < n; i++)
                    begin
                        diff = int'(weight_mem[row][col][i]) - int'(query_mem[(i + p) % n]);
                        acc += longint'(diff) * longint'(diff);
                    end
                    if (p == 0 || acc < unit_d)
                        unit_d = acc;
                end
                if (!found || unit_d < best_d)
                begin
                    found = 1'b1;
                    best_d = unit_d;
                    r.best_row = row[ROW_W-1:0];
                    r.best_col = col[COL_W-1:0];
                end
            end
        if (best_d > longint'(DIST_MAX))
            best_d = longint'(DIST_MAX);
        r.best_distance = best_d[DIST_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Hand one request to the core and update the model when it is taken.
    task automatic send_item(input item_t req, input bit typed, input result_t typed_res);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= req;
        do @(negedge clk); while (!item_ready);
        @(posedge clk);
        items_sent++;
        if (items_sent > QUIET_AFTER)
            quiet = 1'b1;
        if (req.operation == OP_WRITE)
        begin
            weight_mem[req.unit_row][req.unit_col][req.element_index] = req.value;
            weight_set[req.unit_row][req.unit_col][req.element_index] = 1'b1;
        end
        else
        begin
            query_mem[req.element_index] = req.value;
            query_set[req.element_index] = 1'b1;
            if (req.last)
                best_match_q.push_back(typed ? typed_res : find_best_match());
        end
    endtask

    // Registers change only once the core has delivered everything.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        item_valid <= 1'b0;
        while (best_match_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_METRIC_MODE: cyclic_mode = data[0];
            CFG_ROWS_USED: rows_reg = data[CFG_W-1:0];
            CFG_COLS_USED: cols_reg = data[CFG_W-1:0];
            CFG_VEC_LEN: len_reg = data[CFG_W-1:0];
            default: ;
        endcase
    endtask

    function automatic item_t make_item(input op_t op, input int row, input int col,
                                        input int elem, input logic [VAL_W-1:0] v,
                                        input bit last);
        item_t it;
        it.operation = op;
        it.unit_row = row[ROW_W-1:0];
        it.unit_col = col[COL_W-1:0];
        it.element_index = elem[ELEM_W-1:0];
        it.value = v;
        it.last = last;
        return it;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Fill every weight and query entry the next search can read.
    task automatic fill_search_window();
        result_t none;
        none = '0;
        for (int r = 0; r < clamp_count(rows_reg); r++)
            for (int c = 0; c < clamp_count(cols_reg); c++)
                for (int e = 0; e < clamp_count(len_reg); e++)
                    if (!weight_set[r][c][e])
                        send_item(make_item(OP_WRITE, r, c, e, pick_value(), 1'b0), 1'b0, none);
        for (int e = 0; e < clamp_count(len_reg); e++)
            if (!query_set[e])
                send_item(make_item(OP_QUERY, 0, 0, e, pick_value(), 1'b0), 1'b0, none);
    endtask

    // A full query vector in random element order, with last on the final element.
    task automatic send_query_vector();
        int order[$];
        result_t none;
        none = '0;
        for (int e = 0; e < clamp_count(len_reg); e++)
            order.push_back(e);
        order.shuffle();
        foreach (order[k])
            send_item(make_item(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15), order[k],
                                pick_value(), k == order.size() - 1), 1'b0, none);
    endtask

    // Result side: random stalls plus one long hold-off when asked for.
    initial
    begin : result_sink
        int stall_left, hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 7);
                result_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Compare each delivered result with the oldest prediction.
    initial
    begin : result_check
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                matches_seen++;
                if (best_match_q.size() == 0)
                begin
                    $display("[%0t] result with none expected", $realtime);
                    mismatches++;
                end
                else
                begin
                    want = best_match_q.pop_front();
                    if (result.best_row !== want.best_row)
                        report_mismatch("best_row", result.best_row, want.best_row);
                    if (result.best_col !== want.best_col)
                        report_mismatch("best_col", result.best_col, want.best_col);
                    if (result.best_distance !== want.best_distance)
                        report_mismatch("best_distance", result.best_distance,
                                        want.best_distance);
                end
            end
        end
    end

    initial
    begin : stimulus
        step_t plan[$];
        step_t s;
        result_t none, res;
        item_t it;
        int phases, n, pick;
        logic [CFG_DATA_W-1:0] raw [4];
        none = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed steps: extremes, ties, last on a write and one cyclic match.
        s = '{default: '0};
        s.is_reg = 1'b1;
        s.idx = CFG_ROWS_USED; s.data = 16'd1; plan.push_back(s);
        s.idx = CFG_COLS_USED; s.data = 16'd1; plan.push_back(s);
        s.idx = CFG_VEC_LEN; s.data = 16'd1; plan.push_back(s);
        s = '{default: '0};
        s.req = make_item(OP_WRITE, 0, 0, 0, 16'h7FFF, 1'b0); plan.push_back(s);
        s.req = make_item(OP_QUERY, 0, 0, 0, 16'h8000, 1'b1);
        s.typed = 1'b1; s.res = '{4'd0, 4'd0, 36'd4294836225}; plan.push_back(s);
        s.typed = 1'b0;
        s.req = make_item(OP_WRITE, 0, 0, 0, 16'h8000, 1'b0); plan.push_back(s);
        s.req = make_item(OP_QUERY, 15, 15, 0, 16'h8000, 1'b1);
        s.typed = 1'b1; s.res = '{4'd0, 4'd0, 36'd0}; plan.push_back(s);
        s.typed = 1'b0;
        s.req = make_item(OP_WRITE, 15, 15, 15, 16'h1234, 1'b1); plan.push_back(s);
        s.req = make_item(OP_QUERY, 0, 0, 15, 16'h0100, 1'b0); plan.push_back(s);
        s.req = make_item(OP_QUERY, 0, 0, 0, 16'h0000, 1'b1);
        s.typed = 1'b1; s.res = '{4'd0, 4'd0, 36'd1073741824}; plan.push_back(s);
        s = '{default: '0};
        s.is_reg = 1'b1; s.idx = CFG_COLS_USED; s.data = 16'd2; plan.push_back(s);
        s = '{default: '0};
        s.req = make_item(OP_WRITE, 0, 1, 0, 16'h8000, 1'b0); plan.push_back(s);
        s.req = make_item(OP_QUERY, 0, 0, 0, 16'h0000, 1'b1);
        s.typed = 1'b1; s.res = '{4'd0, 4'd0, 36'd1073741824}; plan.push_back(s);
        s = '{default: '0};
        s.is_reg = 1'b1;
        s.idx = CFG_VEC_LEN; s.data = 16'd2; plan.push_back(s);
        s.idx = CFG_METRIC_MODE; s.data = 16'd1; plan.push_back(s);
        s = '{default: '0};
        s.req = make_item(OP_WRITE, 0, 0, 0, 16'h0002, 1'b0); plan.push_back(s);
        s.req = make_item(OP_WRITE, 0, 0, 1, 16'h0001, 1'b0); plan.push_back(s);
        s.req = make_item(OP_WRITE, 0, 1, 0, 16'h0001, 1'b0); plan.push_back(s);
        s.req = make_item(OP_WRITE, 0, 1, 1, 16'h0002, 1'b0); plan.push_back(s);
        s.req = make_item(OP_QUERY, 0, 0, 0, 16'h0001, 1'b0); plan.push_back(s);
        s.req = make_item(OP_QUERY, 0, 0, 1, 16'h0002, 1'b1);
        s.typed = 1'b1; s.res = '{4'd0, 4'd0, 36'd0}; plan.push_back(s);
        s.typed = 1'b0;
        s.req = make_item(OP_QUERY, 0, 0, 0, 16'hFFFB, 1'b1); plan.push_back(s);

        foreach (plan[k])
            if (plan[k].is_reg)
                write_reg(plan[k].idx, plan[k].data);
            else
                send_item(plan[k].req, plan[k].typed, plan[k].res);

        // Random phases: the first few hit the register extremes and clamping.
        phases = 0;
        while (items_sent < ITEM_GOAL)
        begin
            case (phases)
                0: raw = '{16'd1, 16'd0, 16'd17, 16'd0};
                1: raw = '{16'd0, 16'd16, 16'd16, 16'd1};
                2: raw = '{16'd1, 16'd31, 16'd1, 16'd16};
                3: raw = '{16'd0, 16'd1, 16'd16, 16'd16};
                default: raw = '{16'($urandom_range(0, 1)), 16'($urandom_range(0, 4)),
                                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 8))};
            endcase
            for (int i = 0; i < 4; i++)
                write_reg(i[CFG_IDX_W-1:0], (16'($urandom) & 16'hFFE0) | raw[i]);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED + CFG_IDX_W'($urandom_range(0, 250)), 16'($urandom));
            fill_search_window();
            n = clamp_count(len_reg);
            if (phases == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 6; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    send_query_vector();
                else if (pick < 8)
                    repeat ($urandom_range(1, 6))
                        send_item(make_item(OP_WRITE, $urandom_range(0, clamp_count(rows_reg) - 1),
                                            $urandom_range(0, clamp_count(cols_reg) - 1),
                                            $urandom_range(0, n - 1), pick_value(),
                                            $urandom_range(0, 1)), 1'b0, none);
                else
                begin
                    it = item_t'(30'($urandom));
                    it.operation = op_t'($urandom_range(0, 1));
                    it.value = pick_value();
                    it.last = ($urandom_range(0, 3) == 0);
                    send_item(it, 1'b0, none);
                end
            end
            phases++;
        end
        item_valid <= 1'b0;

        while (best_match_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Ran %0d requests over %0d register settings; %0d best matches checked.",
                 items_sent, phases + 3, matches_seen);
        $display("Covered plain and cyclic metrics, clamped sizes and a long result hold-off.");
        if (mismatches == 0)
            $display("som_best_match_unit_search_core test passed");
        else
            $display("som_best_match_unit_search_core test failed");
        $finish;
    end

endmodule
